@@ rtl/fifo_page_replacement_assert.svh @@
// ----------------------------------------------------------------------------
// fifo page replacement assertion macros
// Shared property shorthands, all clocked on clock and idle during reset.
// ----------------------------------------------------------------------------
`ifndef FIFO_PAGE_REPLACEMENT_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_ASSERT_SVH

// condition implies consequence in the same cycle
`define FPR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define FPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fpr_pkg.sv @@
// ----------------------------------------------------------------------------
// fpr_pkg
// Field widths, payload types and controller command/status types.
// ----------------------------------------------------------------------------
package fpr_pkg;

   localparam int PAGE_FIELD_BITS  = 16;
   localparam int SLOT_FIELD_BITS  = 3;
   localparam int COUNT_FIELD_BITS = 16;
   localparam int CFG_BITS         = 4;
   localparam logic [CFG_BITS-1:0] FRAMES_IN_USE_RESET = 4'd8;

   // one page reference
   typedef struct packed {
      logic [PAGE_FIELD_BITS-1:0] page;
      logic                       last;
   } fpr_req_type;

   // one result
   typedef struct packed {
      logic                        hit;
      logic [SLOT_FIELD_BITS-1:0]  slot;
      logic                        evicted_valid;
      logic [PAGE_FIELD_BITS-1:0]  evicted_page;
      logic [COUNT_FIELD_BITS-1:0] hit_total;
      logic [COUNT_FIELD_BITS-1:0] fault_total;
   } fpr_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
   } fpr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_full;
   } fpr_status_type;

endpackage

@@ rtl/fpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpr_ctrl
// Sequencer: capture a request, compare it with the frame table, then update.
// ----------------------------------------------------------------------------
module fpr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fpr_pkg::fpr_status_type status,
   output fpr_pkg::fpr_cmd_type    cmd
);
   import fpr_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            // wait until the output register can take the result
            if (!status.rsp_full) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/fpr_datapath.sv @@
// ----------------------------------------------------------------------------
// fpr_datapath
// Frame table, load pointer, counters, frame count register and result register.
// ----------------------------------------------------------------------------
module fpr_datapath #(
   parameter int FRAMES     = 8,
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fpr_pkg::fpr_cmd_type             cmd,
   output fpr_pkg::fpr_status_type          status,
   input  fpr_pkg::fpr_req_type             req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fpr_pkg::fpr_rsp_type             rsp_payload,
   input  logic                             csr_write_enable,
   input  logic [fpr_pkg::CFG_BITS-1:0]     csr_write_data
);
   import fpr_pkg::*;

   localparam int PTR_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int NUM_W0 = $clog2(FRAMES + 1);
   localparam int NUM_W  = (NUM_W0 > CFG_BITS) ? NUM_W0 : CFG_BITS;
   localparam int PG_W   = (PAGE_BITS > PAGE_FIELD_BITS) ? PAGE_BITS : PAGE_FIELD_BITS;
   localparam int SL_W   = (PTR_W > SLOT_FIELD_BITS) ? PTR_W : SLOT_FIELD_BITS;
   localparam int CT_W   = (COUNT_BITS > COUNT_FIELD_BITS) ? COUNT_BITS : COUNT_FIELD_BITS;

   logic [PAGE_BITS-1:0]  frame_page_ff [FRAMES];
   logic [FRAMES-1:0]     frame_valid_ff;
   logic [PTR_W-1:0]      load_ptr_ff;
   logic [COUNT_BITS-1:0] hit_cnt_ff;
   logic [COUNT_BITS-1:0] fault_cnt_ff;
   logic [CFG_BITS-1:0]   frames_cfg_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic                  last_ff;
   logic [FRAMES-1:0]     match_ff;
   logic [FRAMES-1:0]     match_in;
   fpr_rsp_type           rsp_ff;
   fpr_rsp_type           rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   logic [PG_W-1:0]       req_page_wide;
   logic [NUM_W-1:0]      cfg_wide;
   logic [NUM_W-1:0]      num_frames;
   logic                  hit;
   logic [PTR_W-1:0]      hit_idx;
   logic [PTR_W-1:0]      load_slot;
   logic [PTR_W:0]        ptr_inc;
   logic [PTR_W-1:0]      ptr_next;
   logic                  ev_valid;
   logic [PG_W-1:0]       ev_page_wide;
   logic [SL_W-1:0]       slot_wide;
   logic [COUNT_BITS-1:0] hit_cnt_in;
   logic [COUNT_BITS-1:0] fault_cnt_in;
   logic [CT_W-1:0]       hit_total_wide;
   logic [CT_W-1:0]       fault_total_wide;

   // effective frame count: zero means one, clamp at the table size
   always_comb begin
      cfg_wide = NUM_W'(frames_cfg_ff);
      if (cfg_wide == '0) begin
         num_frames = NUM_W'(1);
      end else if (cfg_wide > NUM_W'(FRAMES)) begin
         num_frames = NUM_W'(FRAMES);
      end else begin
         num_frames = cfg_wide;
      end
   end

   // page extended to the wider of the table and field widths
   assign req_page_wide = PG_W'(req_payload.page);

   // parallel compare against frames in use
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         match_in[i] = frame_valid_ff[i] && (frame_page_ff[i] == page_ff) &&
                       (NUM_W'(i) < num_frames);
      end
   end

   // lowest matching frame
   always_comb begin
      hit_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = PTR_W'(i);
         end
      end
   end
   assign hit = |match_ff;

   // fault target and pointer advance
   assign load_slot = (NUM_W'(load_ptr_ff) < num_frames) ? load_ptr_ff : '0;
   assign ptr_inc   = {1'b0, load_slot} + (PTR_W + 1)'(1);
   assign ptr_next  = (NUM_W'(ptr_inc) >= num_frames) ? '0 : ptr_inc[PTR_W-1:0];
   assign ev_valid  = frame_valid_ff[load_slot];
   assign ev_page_wide = ev_valid ? PG_W'(frame_page_ff[load_slot]) : '0;

   // saturating counters
   always_comb begin
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      if (hit) begin
         if (hit_cnt_ff != '1) begin
            hit_cnt_in = hit_cnt_ff + COUNT_BITS'(1);
         end
      end else begin
         if (fault_cnt_ff != '1) begin
            fault_cnt_in = fault_cnt_ff + COUNT_BITS'(1);
         end
      end
   end

   // result assembly
   assign slot_wide        = hit ? SL_W'(hit_idx) : SL_W'(load_slot);
   assign hit_total_wide   = CT_W'(hit_cnt_in);
   assign fault_total_wide = CT_W'(fault_cnt_in);
   always_comb begin
      rsp_in.hit           = hit;
      rsp_in.slot          = slot_wide[SLOT_FIELD_BITS-1:0];
      rsp_in.evicted_valid = !hit && ev_valid;
      rsp_in.evicted_page  = hit ? '0 : ev_page_wide[PAGE_FIELD_BITS-1:0];
      rsp_in.hit_total     = hit_total_wide[COUNT_FIELD_BITS-1:0];
      rsp_in.fault_total   = fault_total_wide[COUNT_FIELD_BITS-1:0];
   end

   // output register handshake
   assign rsp_valid_in    = cmd.update || (rsp_valid_ff && rsp_stall);
   assign status.rsp_full = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         load_ptr_ff    <= '0;
         hit_cnt_ff     <= '0;
         fault_cnt_ff   <= '0;
         frames_cfg_ff  <= FRAMES_IN_USE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            frames_cfg_ff <= csr_write_data;
         end
         if (cmd.update) begin
            if (last_ff) begin
               // end of string clears the table and counters
               frame_valid_ff <= '0;
               load_ptr_ff    <= '0;
               hit_cnt_ff     <= '0;
               fault_cnt_ff   <= '0;
            end else begin
               hit_cnt_ff   <= hit_cnt_in;
               fault_cnt_ff <= fault_cnt_in;
               if (!hit) begin
                  frame_valid_ff[load_slot] <= 1'b1;
                  load_ptr_ff               <= ptr_next;
               end
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         page_ff <= req_page_wide[PAGE_BITS-1:0];
         last_ff <= req_payload.last;
      end
      if (cmd.lookup) begin
         match_ff <= match_in;
      end
      if (cmd.update) begin
         rsp_ff <= rsp_in;
         if (!hit) begin
            frame_page_ff[load_slot] <= page_ff;
         end
      end
   end

endmodule

@@ rtl/fifo_page_replacement.sv @@
// ----------------------------------------------------------------------------
// fifo_page_replacement
// FIFO page replacement engine. Each request carries one page reference; it is
// compared against every filled frame among the first frames_in_use frames.
// A match is a hit. On a fault the page is loaded into the oldest-loaded frame
// (a round-robin load pointer), reporting the page it displaced. Each result
// carries the hit flag, the frame touched, the evicted page and saturating hit
// and fault counts for the current string; a request with last set clears the
// table and counters after its result. A request passes through capture, a
// registered parallel compare over the frame table, and the table update that
// loads the output register. A new request waits until the prior one updates;
// the update waits while a result is held. The user must write frames_in_use
// through the csr port only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module fifo_page_replacement #(
   parameter int FRAMES     = 8,
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fpr_pkg::fpr_req_type          req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fpr_pkg::fpr_rsp_type          rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [fpr_pkg::CFG_BITS-1:0]  csr_write_data
);
   import fpr_pkg::*;

   `include "fifo_page_replacement_assert.svh"

   fpr_cmd_type    cmd;
   fpr_status_type status;

   // sequencer
   fpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // frame table and counters
   fpr_datapath #(
      .FRAMES     (FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // sequencing checks
   `FPR_ASSERT_NEXT(a_accept_then_lookup, req_valid && !req_stall, cmd.lookup, "no lookup after accept")
   `FPR_ASSERT_NEXT(a_update_then_valid, cmd.update, rsp_valid, "result missing after update")
   `FPR_ASSERT_NOW(a_update_no_overwrite, cmd.update, !(rsp_valid && rsp_stall), "held result overwritten")
   `FPR_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.capture, cmd.lookup, cmd.update}), "overlapping commands")

endmodule
